// File: src/lics_pkg.sv
// Shared constants and controller/datapath command type for the LRU id stack.
`timescale 1ns / 1ps
`default_nettype none
package lics_pkg;

  // Stack geometry
  localparam int ENTRIES = 8;
  localparam int POS_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Field widths
  localparam int ID_W  = 15;
  localparam int HPOS_W = 3;

  // Controller to datapath commands
  typedef struct packed {
    logic load_id;  // capture the incoming request id
    logic update;   // search, reorder the stack and load the result register
  } lics_cmd_t;

endpackage
`default_nettype wire

// File: src/lics_ctrl.sv
// Controller: request handshake, lookup sequencing and result valid tracking.
`timescale 1ns / 1ps
`default_nettype none
module lics_ctrl
  import lics_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  output lics_cmd_t      cmd
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_UPDATE = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  // Result register can be written when empty or being drained this cycle
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd.load_id   = 1'b0;
    cmd.update    = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_id = 1'b1;
          state_nxt   = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          cmd.update    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/lics_dp.sv
// Datapath: recency stack, parallel id compare, reorder and result register.
`timescale 1ns / 1ps
`default_nettype none
module lics_dp
  import lics_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire lics_cmd_t       cmd,
  input  wire logic [ID_W-1:0] in_request_id,
  output logic                 out_hit,
  output logic [HPOS_W-1:0]    out_hit_position,
  output logic                 out_evict_valid,
  output logic [ID_W-1:0]      out_evicted_id
);

  logic [ID_W-1:0]    id_r;
  logic [ID_W-1:0]    slot_ids_r [ENTRIES];
  logic [ID_W-1:0]    slot_ids_nxt [ENTRIES];
  logic [ENTRIES-1:0] slot_valid_r, slot_valid_nxt;

  logic               hit;
  logic [POS_W-1:0]   hit_idx;
  logic [POS_W-1:0]   from_idx;

  logic               hit_r;
  logic [HPOS_W-1:0]  hit_pos_r;
  logic               ev_valid_r;
  logic [ID_W-1:0]    ev_id_r;

  // Compare all slots; the highest matching slot wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid_r[i] && (slot_ids_r[i] == id_r)) begin
        hit     = 1'b1;
        hit_idx = POS_W'(i);
      end
    end
  end

  // Shift down from the hit slot (or slot 0 on a miss), request id on top
  assign from_idx = hit ? hit_idx : '0;

  always_comb begin
    for (int i = 0; i < ENTRIES - 1; i++) begin
      if (POS_W'(i) >= from_idx) begin
        slot_ids_nxt[i]   = slot_ids_r[i+1];
        slot_valid_nxt[i] = slot_valid_r[i+1];
      end else begin
        slot_ids_nxt[i]   = slot_ids_r[i];
        slot_valid_nxt[i] = slot_valid_r[i];
      end
    end
    slot_ids_nxt[ENTRIES-1]   = id_r;
    slot_valid_nxt[ENTRIES-1] = 1'b1;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (cmd.update) begin
      slot_valid_r <= slot_valid_nxt;
    end
  end

  // Id storage, request id and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_id) begin
      id_r <= in_request_id;
    end
    if (cmd.update) begin
      slot_ids_r <= slot_ids_nxt;
      hit_r      <= hit;
      hit_pos_r  <= hit ? HPOS_W'(hit_idx) : '0;
      ev_valid_r <= !hit && slot_valid_r[0];
      ev_id_r    <= (!hit && slot_valid_r[0]) ? slot_ids_r[0] : '0;
    end
  end

  assign out_hit          = hit_r;
  assign out_hit_position = hit_pos_r;
  assign out_evict_valid  = ev_valid_r;
  assign out_evicted_id   = ev_id_r;

endmodule
`default_nettype wire

// File: src/lru_id_cache_stack.sv
// Top level of the LRU id replacement stack.
//
//   channel | ports                         | direction
//   --------+-------------------------------+----------
//   in      | in_valid, in_stall, in_request_id | request in
//   out     | out_valid, out_stall, out_hit, out_hit_position,
//           | out_evict_valid, out_evicted_id   | result out
//
// Each request first has its id captured; then all slots are searched
// in parallel, the stack is reordered and the result register loaded.
// Synchronous active-low reset empties every slot; no clearing pass.
// A held result stalls the search cycle only; the next request is still
// captured while a result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
module lru_id_cache_stack
  import lics_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [ID_W-1:0] in_request_id,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 out_hit,
  output logic [HPOS_W-1:0]    out_hit_position,
  output logic                 out_evict_valid,
  output logic [ID_W-1:0]      out_evicted_id
);

  lics_cmd_t cmd;

  lics_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lics_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_request_id    (in_request_id),
    .out_hit          (out_hit),
    .out_hit_position (out_hit_position),
    .out_evict_valid  (out_evict_valid),
    .out_evicted_id   (out_evicted_id)
  );

endmodule
`default_nettype wire

// File: tb/sv/lru_id_cache_stack_tb.sv
// Self-checking testbench for the LRU id replacement stack.
`timescale 1ns / 1ps
module lru_id_cache_stack_tb;
  import lics_pkg::*;

  localparam int IDLE_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int TAIL_CYCLES = 16;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic              hit;
    logic [HPOS_W-1:0] position;
    logic              evict_valid;
    logic [ID_W-1:0]   evicted_id;
  } lookup_result_t;

  logic            clk;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [ID_W-1:0] in_request_id = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic            out_hit;
  logic [HPOS_W-1:0] out_hit_position;
  logic            out_evict_valid;
  logic [ID_W-1:0] out_evicted_id;

  // Shadow of the recency stack: index 0 is least recent
  logic [ID_W-1:0] held_id [ENTRIES] = '{default: '0};
  logic            held_valid [ENTRIES] = '{default: 1'b0};

  lookup_result_t pending_results[$];
  int failures = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit feed_idle = 1'b1;
  bit drain_idle = 1'b1;

  lru_id_cache_stack dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_request_id    (in_request_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_hit_position (out_hit_position),
    .out_evict_valid  (out_evict_valid),
    .out_evicted_id   (out_evicted_id)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(8, 30);
  endfunction

  // Search top down, move the hit (or the new id) to the top
  function automatic lookup_result_t lru_lookup(input logic [ID_W-1:0] id);
    lookup_result_t r;
    int pos;
    int first;
    pos = -1;
    r = '0;
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (pos < 0 && held_valid[i] && held_id[i] == id) pos = i;
    if (pos >= 0) begin
      r.hit = 1'b1;
      r.position = HPOS_W'(pos);
      first = pos;
    end else begin
      r.evict_valid = held_valid[0];
      r.evicted_id = held_valid[0] ? held_id[0] : '0;
      first = 0;
    end
    for (int i = first; i < ENTRIES - 1; i++) begin
      held_id[i] = held_id[i + 1];
      held_valid[i] = held_valid[i + 1];
    end
    held_id[ENTRIES - 1] = id;
    held_valid[ENTRIES - 1] = 1'b1;
    return r;
  endfunction

  // Called just after the clock rises; returns once the request has been taken.
  // Valid stays high on return so back-to-back requests need no second write.
  task automatic send_request(input logic [ID_W-1:0] id);
    int gap;
    gap = feed_idle ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_request_id <= ID_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_request_id <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(lru_lookup(id));
  endtask

  // One result as text for mismatch reports
  function automatic string result_text(input lookup_result_t r);
    return $sformatf("hit=%0b pos=%0d evict=%0b evicted=%h",
                     r.hit, r.position, r.evict_valid, r.evicted_id);
  endfunction

  task automatic note_failure(input string what, input lookup_result_t want,
                              input lookup_result_t got);
    failures++;
    if (failures <= REPORT_MAX)
      $display("%0t %s: want %s, got %s", $realtime, what,
               result_text(want), result_text(got));
  endtask

  // Result checking and random back-pressure
  always @(posedge clk) begin
    lookup_result_t got;
    lookup_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_hit, out_hit_position, out_evict_valid, out_evicted_id};
      if (pending_results.size() == 0) begin
        note_failure("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) note_failure("mismatch", want, got);
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (drain_idle && $urandom_range(0, 2) == 0) stall_left = idle_length();
    end
  end

  // Watchdog on transfer activity
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("lru_id_cache_stack_tb failed");
        $finish;
      end
    end
  end

  // Empty stack: misses with nothing to evict, id 0 among them
  task automatic test_cold_fill();
    logic [ID_W-1:0] ids [8] = '{15'h0000, 15'h7FFF, 15'h5555, 15'h2AAA,
                                 15'h0001, 15'h4000, 15'h1234, 15'h3FFF};
    foreach (ids[i]) send_request(ids[i]);
  endtask

  // Hit at the top (no reorder), at the bottom, and in the middle
  task automatic test_hit_positions();
    send_request(15'h3FFF);
    send_request(15'h3FFF);
    send_request(15'h0000);
    send_request(15'h2AAA);
  endtask

  // Full stack: misses evict the least recent id, evicted id comes back as a miss
  task automatic test_eviction();
    send_request(15'h6DB6);
    send_request(15'h0249);
    send_request(15'h7FFF);
    send_request(15'h1234);
  endtask

  // Working sets of varying size with some fully random ids mixed in
  task automatic test_random_traffic(input int count);
    logic [ID_W-1:0] pool [16];
    int pool_size;
    int sent;
    int seg;
    sent = 0;
    while (sent < count) begin
      pool_size = $urandom_range(2, 16);
      for (int i = 0; i < pool_size; i++)
        pool[i] = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 15)) : ID_W'($urandom);
      feed_idle = ($urandom_range(0, 3) != 0);
      drain_idle = ($urandom_range(0, 3) != 0);
      seg = $urandom_range(20, 80);
      for (int k = 0; k < seg && sent < count; k++) begin
        if ($urandom_range(0, 99) < 85) send_request(pool[$urandom_range(0, pool_size - 1)]);
        else send_request(ID_W'($urandom));
        sent++;
      end
    end
    feed_idle = 1'b1;
    drain_idle = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_cold_fill();
    test_hit_positions();
    test_eviction();
    test_random_traffic(1135);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("lru_id_cache_stack_tb passed");
    end else begin
      $display("lru_id_cache_stack_tb failed");
    end
    $finish;
  end

endmodule
